@@ rtl/rrqq_pkg.sv @@
package rrqq_pkg;

    localparam int Depth = 64;
    localparam int IdxW = 6;
    localparam int CntW = 7;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_RUN = 3'd1;
    localparam logic [2:0] CMD_LIST = 3'd2;
    localparam logic [2:0] CMD_PEEK = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;

    localparam logic [3:0] ST_ADDED = 4'd0;
    localparam logic [3:0] ST_FULL = 4'd1;
    localparam logic [3:0] ST_DUP = 4'd2;
    localparam logic [3:0] ST_EMPTY = 4'd3;
    localparam logic [3:0] ST_NOTFOUND = 4'd4;
    localparam logic [3:0] ST_REMOVED = 4'd5;
    localparam logic [3:0] ST_FINISHED = 4'd6;
    localparam logic [3:0] ST_REQUEUED = 4'd7;
    localparam logic [3:0] ST_ENTRY = 4'd8;

    localparam logic [15:0] QuantumReset = 16'd5;

    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  prio;
        logic [15:0] time_val;
    } slot_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_HEAD_RD,
        S_HEAD_USE,
        S_LIST_RD,
        S_LIST_OUT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       latch_req;
        logic       ptr_to_head;
        logic       ptr_advance;
        logic       rd_ptr;
        logic       rd_next;
        logic       shift_write;
        logic       add_push;
        logic       run_pop;
        logic       remove_finish;
        logic       load_res;
        logic [3:0] res_status;
        logic [1:0] res_src;
        logic       res_last;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       empty;
        logic       full;
        logic       match;
        logic       at_end;
        logic       shift_end;
        logic       fits;
    } stat_t;

    localparam logic [1:0] SRC_REQ = 2'd0;
    localparam logic [1:0] SRC_RD = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_RUN = 2'd3;

endpackage

@@ rtl/rrqq_if.sv @@
interface rrqq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] pid;
    logic [7:0]  priority_req;
    logic [15:0] time_needed;
    modport source (output valid, command, pid, priority_req, time_needed, input ready);
    modport sink (input valid, command, pid, priority_req, time_needed, output ready);
endinterface

interface rrqq_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [15:0] pid_res;
    logic [7:0]  priority_res;
    logic [15:0] time_left;
    logic [6:0]  occupancy;
    logic        last;
    modport source (output valid, status, pid_res, priority_res, time_left, occupancy, last,
                    input ready);
    modport sink (input valid, status, pid_res, priority_res, time_left, occupancy, last,
                  output ready);
endinterface

interface rrqq_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ rtl/rrqq_ctrl.sv @@
module rrqq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  rrqq_pkg::stat_t st,
    output rrqq_pkg::ctrl_t ctl
);

    rrqq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rrqq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // out register free, or being drained this cycle
    logic out_free;
    assign out_free = !out_valid || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrqq_pkg::S_IDLE:
                if (in_valid) state_next = rrqq_pkg::S_OUT;
            rrqq_pkg::S_OUT:
            begin
                // decode the latched command
                case (st.cmd)
                    rrqq_pkg::CMD_ADD:
                        state_next = st.empty ? rrqq_pkg::S_IDLE : rrqq_pkg::S_SCAN_RD;
                    rrqq_pkg::CMD_REMOVE:
                        state_next = st.empty ? rrqq_pkg::S_IDLE : rrqq_pkg::S_SCAN_RD;
                    rrqq_pkg::CMD_RUN, rrqq_pkg::CMD_PEEK:
                        state_next = st.empty ? rrqq_pkg::S_IDLE : rrqq_pkg::S_HEAD_RD;
                    rrqq_pkg::CMD_LIST:
                        state_next = st.empty ? rrqq_pkg::S_IDLE : rrqq_pkg::S_LIST_RD;
                    default:
                        state_next = rrqq_pkg::S_IDLE;
                endcase
                if (st.empty && (st.cmd == rrqq_pkg::CMD_ADD) && !out_free)
                    state_next = rrqq_pkg::S_OUT;
                if (st.empty && st.cmd != rrqq_pkg::CMD_ADD && st.cmd <= rrqq_pkg::CMD_REMOVE
                    && !out_free)
                    state_next = rrqq_pkg::S_OUT;
            end
            rrqq_pkg::S_SCAN_RD:
                state_next = rrqq_pkg::S_SCAN_CHK;
            rrqq_pkg::S_SCAN_CHK:
            begin
                if (st.match)
                begin
                    if (st.cmd == rrqq_pkg::CMD_ADD)
                    begin
                        if (out_free) state_next = rrqq_pkg::S_IDLE;
                    end
                    else
                        state_next = st.shift_end ? rrqq_pkg::S_SHIFT_WR : rrqq_pkg::S_SHIFT_RD;
                end
                else if (st.at_end)
                begin
                    if (out_free) state_next = rrqq_pkg::S_IDLE;
                end
                else
                    state_next = rrqq_pkg::S_SCAN_RD;
            end
            rrqq_pkg::S_SHIFT_RD:
                state_next = rrqq_pkg::S_SHIFT_WR;
            rrqq_pkg::S_SHIFT_WR:
            begin
                if (st.shift_end)
                begin
                    if (out_free) state_next = rrqq_pkg::S_IDLE;
                end
                else
                    state_next = rrqq_pkg::S_SHIFT_RD;
            end
            rrqq_pkg::S_HEAD_RD:
                state_next = rrqq_pkg::S_HEAD_USE;
            rrqq_pkg::S_HEAD_USE:
                if (out_free) state_next = rrqq_pkg::S_IDLE;
            rrqq_pkg::S_LIST_RD:
                state_next = rrqq_pkg::S_LIST_OUT;
            rrqq_pkg::S_LIST_OUT:
                if (out_free) state_next = st.at_end ? rrqq_pkg::S_IDLE : rrqq_pkg::S_LIST_RD;
            default:
                state_next = rrqq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            rrqq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.latch_req = in_valid;
            end
            rrqq_pkg::S_OUT:
            begin
                ctl.ptr_to_head = 1'b1;
                if (st.empty && out_free && st.cmd != rrqq_pkg::CMD_ADD
                    && st.cmd <= rrqq_pkg::CMD_REMOVE)
                begin
                    ctl.load_res = 1'b1;
                    ctl.res_status = rrqq_pkg::ST_EMPTY;
                    ctl.res_src = rrqq_pkg::SRC_ZERO;
                    ctl.res_last = 1'b1;
                end
                if (st.empty && out_free && st.cmd == rrqq_pkg::CMD_ADD)
                begin
                    ctl.load_res = 1'b1;
                    ctl.res_status = rrqq_pkg::ST_ADDED;
                    ctl.res_src = rrqq_pkg::SRC_REQ;
                    ctl.res_last = 1'b1;
                    ctl.add_push = 1'b1;
                end
            end
            rrqq_pkg::S_SCAN_RD:
                ctl.rd_ptr = 1'b1;
            rrqq_pkg::S_SCAN_CHK:
            begin
                if (st.match)
                begin
                    if (st.cmd == rrqq_pkg::CMD_ADD)
                    begin
                        ctl.load_res = out_free;
                        ctl.res_status = rrqq_pkg::ST_DUP;
                        ctl.res_src = rrqq_pkg::SRC_RD;
                        ctl.res_last = 1'b1;
                    end
                end
                else if (st.at_end)
                begin
                    ctl.load_res = out_free;
                    ctl.res_last = 1'b1;
                    if (st.cmd == rrqq_pkg::CMD_ADD)
                    begin
                        ctl.res_src = rrqq_pkg::SRC_REQ;
                        ctl.res_status = st.full ? rrqq_pkg::ST_FULL : rrqq_pkg::ST_ADDED;
                        ctl.add_push = out_free && !st.full;
                    end
                    else
                    begin
                        ctl.res_src = rrqq_pkg::SRC_ZERO;
                        ctl.res_status = rrqq_pkg::ST_NOTFOUND;
                    end
                end
                else
                    ctl.ptr_advance = 1'b1;
            end
            rrqq_pkg::S_SHIFT_RD:
                ctl.rd_next = 1'b1;
            rrqq_pkg::S_SHIFT_WR:
            begin
                if (st.shift_end)
                begin
                    ctl.load_res = out_free;
                    ctl.remove_finish = out_free;
                    ctl.res_status = rrqq_pkg::ST_REMOVED;
                    ctl.res_src = rrqq_pkg::SRC_REQ;
                    ctl.res_last = 1'b1;
                end
                else
                begin
                    ctl.shift_write = 1'b1;
                    ctl.ptr_advance = 1'b1;
                end
            end
            rrqq_pkg::S_HEAD_RD:
                ctl.rd_ptr = 1'b1;
            rrqq_pkg::S_HEAD_USE:
            begin
                ctl.load_res = out_free;
                ctl.res_last = 1'b1;
                if (st.cmd == rrqq_pkg::CMD_RUN)
                begin
                    ctl.res_src = rrqq_pkg::SRC_RUN;
                    ctl.res_status = st.fits ? rrqq_pkg::ST_FINISHED : rrqq_pkg::ST_REQUEUED;
                    ctl.run_pop = out_free;
                end
                else
                begin
                    ctl.res_src = rrqq_pkg::SRC_RD;
                    ctl.res_status = rrqq_pkg::ST_ENTRY;
                end
            end
            rrqq_pkg::S_LIST_RD:
                ctl.rd_ptr = 1'b1;
            rrqq_pkg::S_LIST_OUT:
            begin
                ctl.load_res = out_free;
                ctl.res_status = rrqq_pkg::ST_ENTRY;
                ctl.res_src = rrqq_pkg::SRC_RD;
                ctl.res_last = st.at_end;
                ctl.ptr_advance = out_free;
            end
            default:
                ctl = '0;
        endcase
    end

endmodule

@@ rtl/rrqq_dp.sv @@
module rrqq_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2:0]      command,
    input  logic [15:0]     pid,
    input  logic [7:0]      priority_req,
    input  logic [15:0]     time_needed,
    input  logic [15:0]     quantum,
    input  rrqq_pkg::ctrl_t ctl,
    output rrqq_pkg::stat_t st,
    output logic [3:0]      status,
    output logic [15:0]     pid_res,
    output logic [7:0]      priority_res,
    output logic [15:0]     time_left,
    output logic [6:0]      occupancy,
    output logic            last
);

    localparam logic [rrqq_pkg::IdxW-1:0] IdxMax = rrqq_pkg::IdxW'(rrqq_pkg::Depth - 1);
    localparam logic [rrqq_pkg::CntW-1:0] CntFull = rrqq_pkg::CntW'(rrqq_pkg::Depth);

    rrqq_pkg::slot_t mem [rrqq_pkg::Depth];

    logic [2:0]                  cmd_reg;
    rrqq_pkg::slot_t             req_reg;
    logic [rrqq_pkg::IdxW-1:0]   head_reg, tail_reg, ptr_reg;
    logic [rrqq_pkg::CntW-1:0]   count_reg, pos_reg;
    rrqq_pkg::slot_t             rd_reg, gone_reg;

    function automatic logic [rrqq_pkg::IdxW-1:0] inc(input logic [rrqq_pkg::IdxW-1:0] i);
        return (i == IdxMax) ? '0 : i + 1'b1;
    endfunction

    logic [rrqq_pkg::IdxW-1:0] ptr_nx;
    assign ptr_nx = inc(ptr_reg);

    logic [16:0] diff;
    assign diff = {1'b0, rd_reg.time_val} - {1'b0, quantum};

    assign st.cmd = cmd_reg;
    assign st.empty = (count_reg == '0);
    assign st.full = (count_reg >= CntFull);
    assign st.match = (rd_reg.pid == req_reg.pid);
    assign st.at_end = (pos_reg + 1'b1 == count_reg);
    assign st.shift_end = (pos_reg + 1'b1 >= count_reg);
    assign st.fits = (rd_reg.time_val <= quantum);

    // memory: one write port, one registered read port
    logic                      wr_en;
    logic [rrqq_pkg::IdxW-1:0] wr_addr;
    rrqq_pkg::slot_t           wr_data;
    logic [rrqq_pkg::IdxW-1:0] rd_addr;

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = tail_reg;
        wr_data = req_reg;
        if (ctl.add_push)
            wr_en = 1'b1;
        else if (ctl.run_pop && !st.fits)
        begin
            wr_en = 1'b1;
            wr_data = '{pid: rd_reg.pid, prio: rd_reg.prio, time_val: diff[15:0]};
        end
        else if (ctl.shift_write)
        begin
            wr_en = 1'b1;
            wr_addr = ptr_reg;
            wr_data = rd_reg;
        end
        rd_addr = ctl.rd_next ? ptr_nx : ptr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (ctl.rd_ptr || ctl.rd_next)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            cmd_reg <= '0;
            ptr_reg <= '0;
            pos_reg <= '0;
            last <= 1'b0;
            status <= '0;
        end
        else
        begin
            if (ctl.latch_req)
                cmd_reg <= command;
            if (ctl.ptr_to_head)
            begin
                ptr_reg <= head_reg;
                pos_reg <= '0;
            end
            else if (ctl.ptr_advance)
            begin
                ptr_reg <= ptr_nx;
                pos_reg <= pos_reg + 1'b1;
            end
            if (ctl.add_push)
            begin
                tail_reg <= inc(tail_reg);
                count_reg <= count_reg + 1'b1;
            end
            if (ctl.run_pop)
            begin
                head_reg <= inc(head_reg);
                if (!st.fits)
                    tail_reg <= inc(tail_reg);
                else
                    count_reg <= count_reg - 1'b1;
            end
            if (ctl.remove_finish)
            begin
                tail_reg <= ptr_reg;
                count_reg <= count_reg - 1'b1;
            end
            if (ctl.load_res)
            begin
                status <= ctl.res_status;
                last <= ctl.res_last;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch_req)
            req_reg <= '{pid: pid, prio: priority_req, time_val: time_needed};
        if (st.match && !ctl.shift_write && !ctl.rd_next && !ctl.remove_finish
            && cmd_reg == rrqq_pkg::CMD_REMOVE && !ctl.ptr_advance)
            gone_reg <= rd_reg;
        if (ctl.load_res)
        begin
            occupancy <= count_reg;
            unique case (ctl.res_src)
                rrqq_pkg::SRC_REQ:
                begin
                    if (ctl.res_status == rrqq_pkg::ST_REMOVED)
                    begin
                        pid_res <= gone_reg.pid;
                        priority_res <= gone_reg.prio;
                        time_left <= gone_reg.time_val;
                        occupancy <= count_reg - 1'b1;
                    end
                    else
                    begin
                        pid_res <= req_reg.pid;
                        priority_res <= req_reg.prio;
                        time_left <= req_reg.time_val;
                        if (ctl.res_status == rrqq_pkg::ST_ADDED)
                            occupancy <= count_reg + 1'b1;
                    end
                end
                rrqq_pkg::SRC_RD:
                begin
                    pid_res <= (ctl.res_status == rrqq_pkg::ST_DUP) ? req_reg.pid : rd_reg.pid;
                    priority_res <= rd_reg.prio;
                    time_left <= rd_reg.time_val;
                end
                rrqq_pkg::SRC_ZERO:
                begin
                    pid_res <= '0;
                    priority_res <= '0;
                    time_left <= '0;
                end
                rrqq_pkg::SRC_RUN:
                begin
                    pid_res <= rd_reg.pid;
                    priority_res <= rd_reg.prio;
                    time_left <= st.fits ? 16'd0 : diff[15:0];
                    if (st.fits)
                        occupancy <= count_reg - 1'b1;
                end
                default:
                    pid_res <= '0;
            endcase
        end
    end

endmodule

@@ rtl/round_robin_quantum_queue.sv @@
// Round-robin process queue of 64 entries (pid, priority, remaining time) held in a
// single-port-write, registered-read memory. Commands are handled one at a time:
// the block takes a new command only when the previous one has produced all of
// its results. Add and remove walk the queue from the head, entry by entry (memory
// read, then compare); remove then shifts the later entries toward the head, each
// one read and then written back one place forward. List emits the entries one at
// a time from the head. Each result sits in an output register until it is
// transferred, and a command waits while that register is full before loading a
// result. The quantum register (reset 5) is written through its own channel, which
// is always ready; write it only while the queue is idle.
module round_robin_quantum_queue (
    input logic   clk,
    input logic   rst_n,
    rrqq_in_if.sink    cmd_in,
    rrqq_out_if.source res_out,
    rrqq_cfg_if.sink   cfg
);

    logic [15:0] quantum_reg;
    logic        out_valid_reg;
    rrqq_pkg::ctrl_t ctl;
    rrqq_pkg::stat_t st;

    assign cfg.ready = 1'b1;

    // quantum register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quantum_reg <= rrqq_pkg::QuantumReset;
        else if (cfg.valid)
            quantum_reg <= cfg.data;
    end

    // output valid: set on each loaded result, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.load_res)
            out_valid_reg <= 1'b1;
        else if (res_out.ready)
            out_valid_reg <= 1'b0;
    end
    assign res_out.valid = out_valid_reg;

    rrqq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_in.valid),
        .in_ready  (cmd_in.ready),
        .out_valid (out_valid_reg),
        .out_ready (res_out.ready),
        .st        (st),
        .ctl       (ctl)
    );

    rrqq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (cmd_in.command),
        .pid          (cmd_in.pid),
        .priority_req (cmd_in.priority_req),
        .time_needed  (cmd_in.time_needed),
        .quantum      (quantum_reg),
        .ctl          (ctl),
        .st           (st),
        .status       (res_out.status),
        .pid_res      (res_out.pid_res),
        .priority_res (res_out.priority_res),
        .time_left    (res_out.time_left),
        .occupancy    (res_out.occupancy),
        .last         (res_out.last)
    );

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_res |-> (!out_valid_reg || res_out.ready))
        else $error("result overwritten before transfer");

    // occupancy never exceeds the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> (res_out.occupancy <= 7'd64))
        else $error("occupancy out of range");

    // commands are never taken in a cycle that loads a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_in.valid && cmd_in.ready) |-> !ctl.load_res)
        else $error("command accepted during result load");

endmodule

@@ tb/sv/rrqq_tb_if.sv @@
`timescale 1ns / 100ps

// The channel interfaces come with the RTL (rrqq_if.sv); this file holds only
// the result type and the scoreboard class that the test top uses.
package rrqq_tb_pkg;

    typedef struct {
        logic [3:0]  status;
        logic [15:0] pid;
        logic [7:0]  prio;
        logic [15:0] time_left;
        logic [6:0]  occupancy;
        logic        last;
    } sched_result_t;

    class sched_scoreboard;
        rrqq_pkg::slot_t procs[$];
        logic [15:0]     quantum;
        sched_result_t   pending[$];
        int              fail_count;
        int              result_count;
        int              status_seen[9];

        function new();
            quantum = rrqq_pkg::QuantumReset;
            fail_count = 0;
            result_count = 0;
        endfunction

        function void push_result(logic [3:0] st, logic [15:0] p, logic [7:0] pr,
                                  logic [15:0] tl, logic lst);
            sched_result_t r;
            r.status = st;
            r.pid = p;
            r.prio = pr;
            r.time_left = tl;
            r.occupancy = 7'(procs.size());
            r.last = lst;
            pending.push_back(r);
        endfunction

        function int find_proc(logic [15:0] p);
            foreach (procs[i])
                if (procs[i].pid == p)
                    return i;
            return -1;
        endfunction

        // Note an accepted command and queue what it should produce.
        function void note_command(logic [2:0] cmd, logic [15:0] p, logic [7:0] pr,
                                   logic [15:0] tn);
            int idx;
            rrqq_pkg::slot_t s;
            if (cmd > rrqq_pkg::CMD_REMOVE)
                return;
            if (cmd == rrqq_pkg::CMD_ADD)
            begin
                idx = find_proc(p);
                if (idx >= 0)
                    push_result(rrqq_pkg::ST_DUP, p, procs[idx].prio, procs[idx].time_val,
                                1'b1);
                else if (procs.size() >= rrqq_pkg::Depth)
                    push_result(rrqq_pkg::ST_FULL, p, pr, tn, 1'b1);
                else
                begin
                    s.pid = p;
                    s.prio = pr;
                    s.time_val = tn;
                    procs.push_back(s);
                    push_result(rrqq_pkg::ST_ADDED, p, pr, tn, 1'b1);
                end
                return;
            end
            if (procs.size() == 0)
            begin
                push_result(rrqq_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
                return;
            end
            case (cmd)
                rrqq_pkg::CMD_RUN:
                begin
                    s = procs.pop_front();
                    if (s.time_val <= quantum)
                        push_result(rrqq_pkg::ST_FINISHED, s.pid, s.prio, '0, 1'b1);
                    else
                    begin
                        s.time_val = s.time_val - quantum;
                        procs.push_back(s);
                        push_result(rrqq_pkg::ST_REQUEUED, s.pid, s.prio, s.time_val, 1'b1);
                    end
                end
                rrqq_pkg::CMD_LIST:
                    foreach (procs[i])
                        push_result(rrqq_pkg::ST_ENTRY, procs[i].pid, procs[i].prio,
                                    procs[i].time_val, i == procs.size() - 1);
                rrqq_pkg::CMD_PEEK:
                    push_result(rrqq_pkg::ST_ENTRY, procs[0].pid, procs[0].prio,
                                procs[0].time_val, 1'b1);
                default:
                begin
                    idx = find_proc(p);
                    if (idx < 0)
                        push_result(rrqq_pkg::ST_NOTFOUND, '0, '0, '0, 1'b1);
                    else
                    begin
                        s = procs[idx];
                        procs.delete(idx);
                        push_result(rrqq_pkg::ST_REMOVED, s.pid, s.prio, s.time_val, 1'b1);
                    end
                end
            endcase
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result, status %0d pid %0d", got.status, got.pid);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            result_count++;
            if (want.status < 9)
                status_seen[want.status]++;
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                fail_count++;
            end
            if (got.pid !== want.pid)
            begin
                $error("pid_res: expected %0d, actual %0d", want.pid, got.pid);
                fail_count++;
            end
            if (got.prio !== want.prio)
            begin
                $error("priority_res: expected %0d, actual %0d", want.prio, got.prio);
                fail_count++;
            end
            if (got.time_left !== want.time_left)
            begin
                $error("time_left: expected %0d, actual %0d", want.time_left, got.time_left);
                fail_count++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
                fail_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                fail_count++;
            end
        endfunction
    endclass
endpackage

@@ tb/sv/round_robin_quantum_queue_test.sv @@
`timescale 1ns / 100ps

module round_robin_quantum_queue_test;

    logic clk;
    logic rst_n;

    rrqq_in_if  cmd_ch();
    rrqq_out_if res_ch();
    rrqq_cfg_if cfg_ch();

    round_robin_quantum_queue dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_ch.sink),
        .res_out (res_ch.source),
        .cfg     (cfg_ch.sink)
    );

    rrqq_tb_pkg::sched_scoreboard board;
    // Cleared near the end so the last part of the run has no idling.
    bit  allow_gaps;
    int  cmd_count;
    logic [15:0] pid_pool[8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Generous ceiling: about 460 commands, each with up to 64 results that may
    // all be stalled, plus the drains.
    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: sample at the rising edge, toggle ready at the falling edge.
    initial
    begin
        rrqq_tb_pkg::sched_result_t got;
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (allow_gaps && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                gap = $urandom_range(1, 18);
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.status = res_ch.status;
                got.pid = res_ch.pid_res;
                got.prio = res_ch.priority_res;
                got.time_left = res_ch.time_left;
                got.occupancy = res_ch.occupancy;
                got.last = res_ch.last;
                board.check_result(got);
            end
        end
    end

    // Drive one command and hold it until the transfer; valid stays high so
    // another command can follow right away. The next gap or drain drops it.
    task automatic send_cmd(logic [2:0] cmd, logic [15:0] p, logic [7:0] pr,
                            logic [15:0] tn);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.pid <= p;
        cmd_ch.priority_req <= pr;
        cmd_ch.time_needed <= tn;
        do
            @(posedge clk);
        while (!(cmd_ch.valid && cmd_ch.ready));
        board.note_command(cmd, p, pr, tn);
        cmd_count++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected result, then cover the tail of a
    // command that produces nothing (undefined opcodes).
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_quantum(logic [15:0] q);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= q;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        board.quantum = q;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly known pids so duplicates and removes hit; sometimes fully random.
    function automatic logic [15:0] pick_pid();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return pid_pool[$urandom_range(0, 7)];
    endfunction

    task automatic random_phase(int n, int max_occ);
        int w;
        logic [2:0] cmd;
        for (int i = 0; i < n; i++)
        begin
            w = $urandom_range(0, 99);
            if (w < 40 && board.procs.size() < max_occ)
                cmd = rrqq_pkg::CMD_ADD;
            else if (w < 62)
                cmd = rrqq_pkg::CMD_RUN;
            else if (w < 70)
                cmd = rrqq_pkg::CMD_LIST;
            else if (w < 80)
                cmd = rrqq_pkg::CMD_PEEK;
            else if (w < 96)
                cmd = rrqq_pkg::CMD_REMOVE;
            else
                cmd = 3'($urandom_range(5, 7));
            send_cmd(cmd, pick_pid(), 8'($urandom), 16'(($urandom_range(0, 3) == 0) ?
                     $urandom : $urandom_range(0, 40)));
        end
    endtask

    initial
    begin
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        allow_gaps = 1'b1;
        cmd_count = 0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = rrqq_pkg::CMD_ADD;
        cmd_ch.pid = '0;
        cmd_ch.priority_req = '0;
        cmd_ch.time_needed = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        foreach (pid_pool[i])
            pid_pool[i] = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty queue on every non-add command, field extremes,
        // duplicate add, absent remove, finish and requeue, undefined opcode.
        send_cmd(rrqq_pkg::CMD_RUN, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_LIST, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_PEEK, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_REMOVE, 16'hFFFF, '0, '0);
        send_cmd(3'd5, '0, '0, '0);
        send_cmd(3'd7, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_cmd(rrqq_pkg::CMD_ADD, 16'h0000, 8'h00, 16'h0000);
        send_cmd(rrqq_pkg::CMD_ADD, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_cmd(rrqq_pkg::CMD_ADD, 16'h1234, 8'h5A, 16'd5);
        send_cmd(rrqq_pkg::CMD_ADD, 16'hFFFF, 8'h01, 16'd1);
        send_cmd(rrqq_pkg::CMD_LIST, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_PEEK, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_RUN, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_RUN, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_RUN, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_REMOVE, 16'hABCD, '0, '0);
        send_cmd(rrqq_pkg::CMD_REMOVE, 16'hFFFF, '0, '0);
        send_cmd(3'd6, '0, '0, '0);

        // Zero quantum: zero-time entries finish, others requeue unchanged.
        write_quantum(16'd0);
        send_cmd(rrqq_pkg::CMD_ADD, 16'd7, 8'd3, 16'd0);
        send_cmd(rrqq_pkg::CMD_ADD, 16'd8, 8'd4, 16'd9);
        send_cmd(rrqq_pkg::CMD_RUN, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_RUN, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_RUN, '0, '0, '0);

        // Fill to full, then full and duplicate adds, a long list, removes.
        write_quantum(16'hFFFF);
        while (board.procs.size() < rrqq_pkg::Depth)
            send_cmd(rrqq_pkg::CMD_ADD, 16'($urandom), 8'($urandom), 16'($urandom));
        send_cmd(rrqq_pkg::CMD_ADD, board.procs[rrqq_pkg::Depth - 1].pid ^ 16'h8000,
                 8'h11, 16'd3);
        send_cmd(rrqq_pkg::CMD_ADD, board.procs[10].pid, 8'h22, 16'd4);
        send_cmd(rrqq_pkg::CMD_LIST, '0, '0, '0);
        send_cmd(rrqq_pkg::CMD_REMOVE, board.procs[rrqq_pkg::Depth - 1].pid, '0, '0);
        send_cmd(rrqq_pkg::CMD_REMOVE, board.procs[0].pid, '0, '0);
        send_cmd(rrqq_pkg::CMD_REMOVE, board.procs[30].pid, '0, '0);
        // Hold off the sender until everything has come back.
        drain();
        while (board.procs.size() > 0)
            send_cmd(rrqq_pkg::CMD_RUN, '0, '0, '0);

        write_quantum(16'd1);
        random_phase(100, 12);
        write_quantum(16'd5);
        random_phase(100, 64);
        write_quantum(16'($urandom_range(2, 30)));
        random_phase(60, 8);
        allow_gaps = 1'b0;
        random_phase(50, 16);

        drain();
        $display("Ran %0d commands, checked %0d results (finished %0d, requeued %0d,",
                 cmd_count, board.result_count, board.status_seen[rrqq_pkg::ST_FINISHED],
                 board.status_seen[rrqq_pkg::ST_REQUEUED]);
        $display("  removed %0d, duplicate %0d, full %0d) over five quantum settings.",
                 board.status_seen[rrqq_pkg::ST_REMOVED], board.status_seen[rrqq_pkg::ST_DUP],
                 board.status_seen[rrqq_pkg::ST_FULL]);
        if (board.fail_count == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/rrqq_pkg.sv
rtl/rrqq_if.sv
rtl/rrqq_ctrl.sv
rtl/rrqq_dp.sv
rtl/round_robin_quantum_queue.sv
tb/sv/rrqq_tb_if.sv
tb/sv/round_robin_quantum_queue_test.sv
